### rtl/core/capwap_header_parser_top_assert.svh
// Assertion helpers used by the checker file.
`ifndef CAPWAP_HEADER_PARSER_TOP_ASSERT_SVH
`define CAPWAP_HEADER_PARSER_TOP_ASSERT_SVH

// Clocked assertion, masked while reset is applied.
`define CHP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define CHP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/chp_pkg.sv
`timescale 1ns / 1ps

package chp_pkg;

    // result codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_PREAMBLE = 3'd1;
    localparam logic [2:0] ST_WBID     = 3'd2;
    localparam logic [2:0] ST_HLEN     = 3'd3;
    localparam logic [2:0] ST_MAC_LEN  = 3'd4;
    localparam logic [2:0] ST_INFO_LEN = 3'd5;
    localparam logic [2:0] ST_TRUNC    = 3'd6;

    localparam logic [4:0] HDR_BYTES   = 5'd8;
    localparam logic [4:0] POS_MAX     = 5'd31;
    localparam logic [4:0] MAC_END_S   = 5'd16;
    localparam logic [4:0] MAC_END_L   = 5'd20;
    localparam logic [4:0] INFO_LAST   = 5'd4;
    localparam logic [3:0] MAC_LEN_S   = 4'd6;
    localparam logic [3:0] MAC_LEN_L   = 4'd8;
    localparam logic [7:0] INFO_LEN    = 8'd4;
    localparam logic [4:0] WBID_80211  = 5'd1;

    typedef struct packed {
        logic [2:0]  status;
        logic [4:0]  header_len_words;
        logic [4:0]  radio_num;
        logic [4:0]  binding_id;
        logic [5:0]  flag_bits;
        logic [15:0] frag_id;
        logic [12:0] fragment_offset;
        logic [3:0]  mac_length;
        logic [63:0] mac_value;
        logic [7:0]  signal_strength;
        logic [7:0]  noise_ratio;
        logic [15:0] data_rate;
    } chp_result_t;

endpackage

### rtl/core/chp_intf.sv
`timescale 1ns / 1ps

interface chp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface chp_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [4:0]  header_len_words;
    logic [4:0]  radio_num;
    logic [4:0]  binding_id;
    logic [5:0]  flag_bits;
    logic [15:0] frag_id;
    logic [12:0] fragment_offset;
    logic [3:0]  mac_length;
    logic [63:0] mac_value;
    logic [7:0]  signal_strength;
    logic [7:0]  noise_ratio;
    logic [15:0] data_rate;

    modport source (
        output valid, output status, output header_len_words, output radio_num,
        output binding_id, output flag_bits, output frag_id, output fragment_offset,
        output mac_length, output mac_value, output signal_strength,
        output noise_ratio, output data_rate, input ready
    );
    modport sink (
        input valid, input status, input header_len_words, input radio_num,
        input binding_id, input flag_bits, input frag_id, input fragment_offset,
        input mac_length, input mac_value, input signal_strength,
        input noise_ratio, input data_rate, output ready
    );
endinterface

### rtl/core/chp_parse.sv
`timescale 1ns / 1ps

module chp_parse
    import chp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        advance,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        res_valid,
    output chp_result_t res
);

    logic [4:0]  pos_reg, pos_next;
    logic [63:0] hdr_reg, hdr_next;
    logic [3:0]  mac_len_reg, mac_len_next;
    logic [63:0] mac_reg, mac_next;
    logic [31:0] info_reg, info_next;
    logic        skip_reg, skip_next;

    logic        have;
    logic [2:0]  code;
    logic        flag_w, flag_m;
    logic [4:0]  hlen, wbid;
    logic [4:0]  need_words;
    logic [4:0]  mac_end;
    logic [4:0]  mac_last;
    logic [4:0]  rec_start;
    logic [4:0]  info_pos;
    logic        ok;
    logic        emit;

    always_comb
    begin
        hdr_next     = hdr_reg;
        mac_len_next = mac_len_reg;
        mac_next     = mac_reg;
        info_next    = info_reg;
        have         = 1'b0;
        code         = ST_OK;

        if (pos_reg < HDR_BYTES)
        begin
            for (int i = 0; i < 8; i++)
            begin
                if (pos_reg[2:0] == 3'(i))
                begin
                    hdr_next[8*(7-i) +: 8] = hdr_reg[8*(7-i) +: 8] | data_byte;
                end
            end
        end

        flag_w     = hdr_next[37];
        flag_m     = hdr_next[36];
        hlen       = hdr_next[55:51];
        wbid       = hdr_next[45:41];
        need_words = 5'd2 + (flag_w ? 5'd2 : 5'd0) + (flag_m ? 5'd2 : 5'd0);
        mac_end    = (mac_len_reg == MAC_LEN_L) ? MAC_END_L : MAC_END_S;
        mac_last   = HDR_BYTES + {1'b0, mac_len_reg};
        rec_start  = flag_m ? mac_end : HDR_BYTES;
        info_pos   = pos_reg - rec_start;

        if (pos_reg < HDR_BYTES)
        begin
            if (pos_reg == 5'd0 && data_byte != 8'd0)
            begin
                have = 1'b1;
                code = ST_PREAMBLE;
            end
            else if (pos_reg == HDR_BYTES - 5'd1)
            begin
                priority if (flag_w && wbid != WBID_80211)
                begin
                    have = 1'b1;
                    code = ST_WBID;
                end
                else if (hlen < need_words)
                begin
                    have = 1'b1;
                    code = ST_HLEN;
                end
                else if (!flag_m && !flag_w)
                begin
                    have = 1'b1;
                end
            end
        end
        else if (flag_m && pos_reg < mac_end)
        begin
            if (pos_reg == HDR_BYTES)
            begin
                if (data_byte != 8'(MAC_LEN_S) && data_byte != 8'(MAC_LEN_L))
                begin
                    have = 1'b1;
                    code = ST_MAC_LEN;
                end
                else
                begin
                    mac_len_next = data_byte[3:0];
                end
            end
            else if (pos_reg <= mac_last)
            begin
                mac_next = {mac_reg[55:0], data_byte};
                if (pos_reg == mac_last && !flag_w)
                begin
                    have = 1'b1;
                end
            end
        end
        else if (flag_w)
        begin
            if (info_pos == 5'd0)
            begin
                if (data_byte != INFO_LEN)
                begin
                    have = 1'b1;
                    code = ST_INFO_LEN;
                end
            end
            else if (info_pos <= INFO_LAST)
            begin
                info_next = {info_reg[23:0], data_byte};
                if (info_pos == INFO_LAST)
                begin
                    have = 1'b1;
                end
            end
        end
    end

    // a result from parsing wins; otherwise an unfinished packet ends as truncated
    assign emit      = !skip_reg && (have || last_byte);
    assign res_valid = advance && emit;
    assign ok        = have && (code == ST_OK);

    always_comb
    begin
        res                  = '0;
        res.status           = have ? code : ST_TRUNC;
        res.header_len_words = hdr_next[55:51];
        res.radio_num        = hdr_next[50:46];
        res.binding_id       = hdr_next[45:41];
        res.flag_bits        = hdr_next[40:35];
        res.frag_id          = hdr_next[31:16];
        res.fragment_offset  = hdr_next[15:3];
        if (ok && flag_m)
        begin
            res.mac_length = mac_len_next;
            res.mac_value  = (mac_len_next == MAC_LEN_S) ? {mac_next[47:0], 16'd0} : mac_next;
        end
        if (ok && flag_w)
        begin
            res.signal_strength = info_next[31:24];
            res.noise_ratio     = info_next[23:16];
            res.data_rate       = info_next[15:0];
        end
    end

    always_comb
    begin
        pos_next  = pos_reg;
        skip_next = skip_reg;
        if (!skip_reg)
        begin
            pos_next  = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 5'd1;
            skip_next = have;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            hdr_reg     <= '0;
            mac_len_reg <= '0;
            mac_reg     <= '0;
            info_reg    <= '0;
            skip_reg    <= 1'b0;
        end
        else if (advance)
        begin
            if (last_byte)
            begin
                pos_reg     <= '0;
                hdr_reg     <= '0;
                mac_len_reg <= '0;
                mac_reg     <= '0;
                info_reg    <= '0;
                skip_reg    <= 1'b0;
            end
            else if (!skip_reg)
            begin
                pos_reg     <= pos_next;
                hdr_reg     <= hdr_next;
                mac_len_reg <= mac_len_next;
                mac_reg     <= mac_next;
                info_reg    <= info_next;
                skip_reg    <= skip_next;
            end
        end
    end

endmodule

### rtl/core/chp_obuf.sv
`timescale 1ns / 1ps

module chp_obuf
    import chp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  chp_result_t push_data,
    output logic        space,
    output logic        out_valid,
    input  logic        out_ready,
    output chp_result_t out_data
);

    chp_result_t head_reg, skid_reg;
    logic [1:0]  count_reg, count_next;
    logic        pop;
    logic        head_from_in, head_from_skid, skid_load;

    assign pop       = out_valid && out_ready;
    assign out_valid = count_reg != 2'd0;
    assign space     = count_reg != 2'd2;
    assign out_data  = head_reg;

    always_comb
    begin
        count_next     = count_reg;
        head_from_in   = 1'b0;
        head_from_skid = 1'b0;
        skid_load      = 1'b0;
        unique case (count_reg)
            2'd0:
            begin
                if (push)
                begin
                    head_from_in = 1'b1;
                    count_next   = 2'd1;
                end
            end
            2'd1:
            begin
                if (push && pop)
                begin
                    head_from_in = 1'b1;
                end
                else if (push)
                begin
                    skid_load  = 1'b1;
                    count_next = 2'd2;
                end
                else if (pop)
                begin
                    count_next = 2'd0;
                end
            end
            2'd2:
            begin
                if (pop)
                begin
                    head_from_skid = 1'b1;
                    count_next     = 2'd1;
                end
            end
            default:
            begin
                count_next = 2'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (head_from_in)
        begin
            head_reg <= push_data;
        end
        else if (head_from_skid)
        begin
            head_reg <= skid_reg;
        end
        if (skid_load)
        begin
            skid_reg <= push_data;
        end
    end

endmodule

### rtl/core/capwap_header_parser_top.sv
`timescale 1ns / 1ps
// A result enters the output buffer as the byte that decides it is transferred, behind any waiting result.
// Throughput: one packet byte per cycle while pkt.ready is high; the per-byte parse is a position counter and capture.
// A two-entry output buffer keeps bytes flowing while one result waits; pkt.ready drops
// only when both entries are full.
// Reset (rst_n low, asynchronous) clears the parse state and empties the output buffer.

module capwap_header_parser_top
    import chp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    chp_byte_if.sink     pkt,
    chp_result_if.source parsed
);

    logic        space;
    logic        advance;
    logic        res_valid;
    chp_result_t res;
    chp_result_t head;

    assign pkt.ready = space;
    assign advance   = pkt.valid && space;

    chp_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .data_byte (pkt.data_byte),
        .last_byte (pkt.last_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    chp_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .space     (space),
        .out_valid (parsed.valid),
        .out_ready (parsed.ready),
        .out_data  (head)
    );

    assign parsed.status           = head.status;
    assign parsed.header_len_words = head.header_len_words;
    assign parsed.radio_num        = head.radio_num;
    assign parsed.binding_id       = head.binding_id;
    assign parsed.flag_bits        = head.flag_bits;
    assign parsed.frag_id          = head.frag_id;
    assign parsed.fragment_offset  = head.fragment_offset;
    assign parsed.mac_length       = head.mac_length;
    assign parsed.mac_value        = head.mac_value;
    assign parsed.signal_strength  = head.signal_strength;
    assign parsed.noise_ratio      = head.noise_ratio;
    assign parsed.data_rate        = head.data_rate;

endmodule

### rtl/core/chp_checker.sv
`timescale 1ns / 1ps
`include "capwap_header_parser_top_assert.svh"

module chp_checker
    import chp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  status,
    input logic [5:0]  flag_bits,
    input logic [3:0]  mac_length,
    input logic [63:0] mac_value,
    input logic [7:0]  signal_strength,
    input logic [15:0] data_rate
);

    `CHP_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result withdrawn while stalled")
    `CHP_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(status) && $stable(mac_value), "stalled result changed")
    `CHP_ASSERT(a_err_no_records, out_valid && status != ST_OK |-> mac_length == 4'd0 && mac_value == 64'd0 && signal_strength == 8'd0 && data_rate == 16'd0, "error result carries record data")
    `CHP_ASSERT(a_ok_mac_len, out_valid && status == ST_OK && flag_bits[1] |-> mac_length == MAC_LEN_S || mac_length == MAC_LEN_L, "bad MAC length on success")
    `CHP_ASSERT_ALWAYS(a_status_code, out_valid |-> status <= ST_TRUNC, "undefined status code")

endmodule

bind capwap_header_parser_top chp_checker u_chp_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (parsed.valid),
    .out_ready       (parsed.ready),
    .status          (parsed.status),
    .flag_bits       (parsed.flag_bits),
    .mac_length      (parsed.mac_length),
    .mac_value       (parsed.mac_value),
    .signal_strength (parsed.signal_strength),
    .data_rate       (parsed.data_rate)
);

### tb/tb_capwap_header_parser_top.sv
`timescale 1ns / 1ps

module tb_capwap_header_parser_top;
    import chp_pkg::*;

    localparam int CLK_HALF    = 4;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_BYTES = 435;
    localparam int DRAIN_WAIT  = 20;
    localparam int FLAG_W      = 2;
    localparam int FLAG_M      = 1;

    typedef struct {
        logic [7:0] data;
        logic       last;
        bit         drain;
    } byte_item_t;

    logic clk = 1'b0;
    logic rst_n;

    chp_byte_if   pkt_if();
    chp_result_if parsed_if();

    capwap_header_parser_top u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .pkt    (pkt_if),
        .parsed (parsed_if)
    );

    always #(CLK_HALF) clk = ~clk;

    byte_item_t  byte_q[$];
    logic [7:0]  pkt_buf[$];
    chp_result_t expected_parses[$];
    int          tx_idle_pct;
    int          rx_idle_pct;
    int          fail_count;
    int          cycle_count;
    bit          pkt_taken;

    // parser state kept by the predictor
    logic [4:0]  cur_pos;
    logic [63:0] hdr_bytes;
    logic [3:0]  rec_mac_len;
    logic [63:0] rec_mac;
    logic [31:0] rec_info;
    bit          drop_rest;

    task automatic clear_parse_state();
        cur_pos     = '0;
        hdr_bytes   = '0;
        rec_mac_len = '0;
        rec_mac     = '0;
        rec_info    = '0;
        drop_rest   = 1'b0;
    endtask

    function automatic chp_result_t make_result(input logic [2:0] st, input bit ok);
        chp_result_t r;
        r                  = '0;
        r.status           = st;
        r.header_len_words = hdr_bytes[55:51];
        r.radio_num        = hdr_bytes[50:46];
        r.binding_id       = hdr_bytes[45:41];
        r.flag_bits        = hdr_bytes[40:35];
        r.frag_id          = hdr_bytes[31:16];
        r.fragment_offset  = hdr_bytes[15:3];
        if (ok && hdr_bytes[32 + 4])
        begin
            r.mac_length = rec_mac_len;
            r.mac_value  = (rec_mac_len == MAC_LEN_S) ? (rec_mac << 16) : rec_mac;
        end
        if (ok && hdr_bytes[32 + 5])
        begin
            r.signal_strength = rec_info[31:24];
            r.noise_ratio     = rec_info[23:16];
            r.data_rate       = rec_info[15:0];
        end
        return r;
    endfunction

    task automatic parse_header_byte(input logic [7:0] b, input logic last);
        int         pos;
        int         need;
        int         mac_end;
        int         start;
        int         p;
        bit         has_m;
        bit         has_w;
        bit         done;
        logic [2:0] st;
        done = 1'b0;
        st   = ST_OK;
        if (!drop_rest)
        begin
            pos = int'(cur_pos);
            if (pos < int'(HDR_BYTES))
            begin
                hdr_bytes[63 - 8 * pos -: 8] = b;
                has_m = hdr_bytes[32 + 4];
                has_w = hdr_bytes[32 + 5];
                if (pos == 0 && b != 8'h00)
                begin
                    st   = ST_PREAMBLE;
                    done = 1'b1;
                end
                else if (pos == int'(HDR_BYTES) - 1)
                begin
                    need = 8 + (has_w ? 8 : 0) + (has_m ? 8 : 0);
                    if (has_w && hdr_bytes[45:41] != WBID_80211)
                    begin
                        st   = ST_WBID;
                        done = 1'b1;
                    end
                    else if (int'(hdr_bytes[55:51]) < need / 4)
                    begin
                        st   = ST_HLEN;
                        done = 1'b1;
                    end
                    else if (!has_m && !has_w)
                    begin
                        done = 1'b1;
                    end
                end
            end
            else
            begin
                has_m   = hdr_bytes[32 + 4];
                has_w   = hdr_bytes[32 + 5];
                mac_end = (rec_mac_len == MAC_LEN_L) ? int'(MAC_END_L) : int'(MAC_END_S);
                if (has_m && pos < mac_end)
                begin
                    if (pos == int'(HDR_BYTES))
                    begin
                        if (b != 8'(MAC_LEN_S) && b != 8'(MAC_LEN_L))
                        begin
                            st   = ST_MAC_LEN;
                            done = 1'b1;
                        end
                        else
                        begin
                            rec_mac_len = b[3:0];
                        end
                    end
                    else if (pos <= int'(HDR_BYTES) + int'(rec_mac_len))
                    begin
                        rec_mac = {rec_mac[55:0], b};
                        if (pos == int'(HDR_BYTES) + int'(rec_mac_len) && !has_w)
                            done = 1'b1;
                    end
                end
                else if (has_w)
                begin
                    start = has_m ? mac_end : int'(HDR_BYTES);
                    p     = pos - start;
                    if (p == 0)
                    begin
                        if (b != INFO_LEN)
                        begin
                            st   = ST_INFO_LEN;
                            done = 1'b1;
                        end
                    end
                    else if (p <= int'(INFO_LAST))
                    begin
                        rec_info = {rec_info[23:0], b};
                        if (p == int'(INFO_LAST))
                            done = 1'b1;
                    end
                end
            end
            if (cur_pos != POS_MAX)
                cur_pos = cur_pos + 5'd1;
            if (done)
            begin
                expected_parses.push_back(make_result(st, st == ST_OK));
                drop_rest = 1'b1;
            end
        end
        if (last)
        begin
            if (!drop_rest)
                expected_parses.push_back(make_result(ST_TRUNC, 1'b0));
            clear_parse_state();
        end
    endtask

    task automatic queue_packet(input bit hold);
        int i;
        for (i = 0; i < pkt_buf.size(); i++)
            byte_q.push_back('{pkt_buf[i], (i == pkt_buf.size() - 1), (hold && i == 0)});
    endtask

    // one packet: mostly well formed with random content, some faults,
    // some cut short or run on, some plain noise
    task automatic add_packet(input bit hold, output int used);
        int          kind;
        int          need_words;
        int          n;
        int          r;
        bit          has_m;
        bit          has_w;
        logic [4:0]  hlen;
        logic [4:0]  rid;
        logic [4:0]  wbid;
        logic [5:0]  flags;
        logic [3:0]  mlen;
        logic [7:0]  b0;
        logic [7:0]  mac_len_byte;
        logic [7:0]  info_len_byte;
        logic [23:0] hdr_word;
        logic [31:0] tail;
        pkt_buf.delete();
        kind = int'($urandom_range(99));
        if (kind < 8)
        begin
            n = int'($urandom_range(12, 1));
            repeat (n) pkt_buf.push_back(8'($urandom));
            used = 1;
        end
        else
        begin
            has_m         = 1'($urandom_range(1));
            has_w         = 1'($urandom_range(1));
            need_words    = 2 + (has_m ? 2 : 0) + (has_w ? 2 : 0);
            hlen          = 5'($urandom_range(31, need_words));
            rid           = 5'($urandom);
            wbid          = has_w ? WBID_80211 : 5'($urandom);
            flags         = 6'($urandom);
            flags[FLAG_W] = has_w;
            flags[FLAG_M] = has_m;
            mlen          = $urandom_range(1) ? MAC_LEN_L : MAC_LEN_S;
            mac_len_byte  = {4'h0, mlen};
            info_len_byte = INFO_LEN;
            b0            = 8'h00;
            if (kind < 23)
            begin
                case (kind % 5)
                    0: b0 = 8'($urandom_range(255, 1));
                    1: wbid = WBID_80211 ^ 5'($urandom_range(31, 1));
                    2: hlen = 5'($urandom_range(need_words - 1, 0));
                    3:
                    begin
                        do
                            mac_len_byte = 8'($urandom);
                        while (mac_len_byte == 8'(MAC_LEN_S) || mac_len_byte == 8'(MAC_LEN_L));
                    end
                    default:
                    begin
                        do
                            info_len_byte = 8'($urandom);
                        while (info_len_byte == INFO_LEN);
                    end
                endcase
            end
            hdr_word = {hlen, rid, wbid, flags, 3'($urandom)};
            tail     = $urandom;
            pkt_buf  = '{b0, hdr_word[23:16], hdr_word[15:8], hdr_word[7:0],
                         tail[31:24], tail[23:16], tail[15:8], tail[7:0]};
            used = 8;
            if (has_m)
            begin
                pkt_buf.push_back(mac_len_byte);
                repeat (mlen) pkt_buf.push_back(8'($urandom));
                used = pkt_buf.size();
                while (pkt_buf.size() < ((mlen == MAC_LEN_L) ? int'(MAC_END_L) : int'(MAC_END_S)))
                    pkt_buf.push_back(8'($urandom));
            end
            if (has_w)
            begin
                pkt_buf.push_back(info_len_byte);
                repeat (4) pkt_buf.push_back(8'($urandom));
                used = pkt_buf.size();
                repeat (3) pkt_buf.push_back(8'($urandom));
            end
            r = int'($urandom_range(99));
            if (r < 15)
            begin
                n    = int'($urandom_range(used - 1, 1));
                used = n;
            end
            else
            begin
                n = int'($urandom_range(used + 4, used));
            end
            while (pkt_buf.size() < n)
                pkt_buf.push_back(8'($urandom));
            while (pkt_buf.size() > n)
                void'(pkt_buf.pop_back());
            if (r >= 95)
                pkt_buf[$urandom_range(n - 1)] = 8'($urandom);
        end
        // report the bytes actually sent
        used = pkt_buf.size();
        queue_packet(hold);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    // sender and receiver, both move at the falling edge
    always @(negedge clk)
    begin : drive_bytes
        byte_item_t nx;
        logic       v;
        logic [7:0] d;
        logic       l;
        if (rst_n)
        begin
            if (!pkt_if.valid || pkt_taken)
            begin
                v = 1'b0;
                d = pkt_if.data_byte;
                l = pkt_if.last_byte;
                if (byte_q.size() != 0 && !(byte_q[0].drain && expected_parses.size() != 0)
                    && int'($urandom_range(99)) >= tx_idle_pct)
                begin
                    nx = byte_q.pop_front();
                    v  = 1'b1;
                    d  = nx.data;
                    l  = nx.last;
                end
                pkt_if.valid     <= v;
                pkt_if.data_byte <= d;
                pkt_if.last_byte <= l;
            end
            parsed_if.ready <= (int'($urandom_range(99)) >= rx_idle_pct);
        end
    end

    // results are checked before the byte of this edge is predicted
    always @(posedge clk)
    begin : monitor
        chp_result_t want;
        if (rst_n)
        begin
            if (parsed_if.valid && parsed_if.ready)
            begin
                if (expected_parses.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, actual status %0d",
                             $time, parsed_if.status);
                    fail_count++;
                end
                else
                begin
                    want = expected_parses.pop_front();
                    check_field("status", 64'(want.status), 64'(parsed_if.status));
                    check_field("header_len_words", 64'(want.header_len_words),
                                64'(parsed_if.header_len_words));
                    check_field("radio_num", 64'(want.radio_num), 64'(parsed_if.radio_num));
                    check_field("binding_id", 64'(want.binding_id),
                                64'(parsed_if.binding_id));
                    check_field("flag_bits", 64'(want.flag_bits), 64'(parsed_if.flag_bits));
                    check_field("frag_id", 64'(want.frag_id), 64'(parsed_if.frag_id));
                    check_field("fragment_offset", 64'(want.fragment_offset),
                                64'(parsed_if.fragment_offset));
                    check_field("mac_length", 64'(want.mac_length),
                                64'(parsed_if.mac_length));
                    check_field("mac_value", want.mac_value, parsed_if.mac_value);
                    check_field("signal_strength", 64'(want.signal_strength),
                                64'(parsed_if.signal_strength));
                    check_field("noise_ratio", 64'(want.noise_ratio),
                                64'(parsed_if.noise_ratio));
                    check_field("data_rate", 64'(want.data_rate), 64'(parsed_if.data_rate));
                end
            end
            pkt_taken <= pkt_if.valid && pkt_if.ready;
            if (pkt_if.valid && pkt_if.ready)
                parse_header_byte(pkt_if.data_byte, pkt_if.last_byte);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin : stimulus
        int used;
        int n;
        int phase;
        pkt_if.valid     = 1'b0;
        pkt_if.data_byte = 8'h00;
        pkt_if.last_byte = 1'b0;
        parsed_if.ready  = 1'b0;
        rst_n            = 1'b0;
        pkt_taken        = 1'b0;
        fail_count       = 0;
        cycle_count      = 0;
        tx_idle_pct      = 14;
        rx_idle_pct      = 48;
        clear_parse_state();

        // directed: bad preamble, one-byte truncation, all-ones header save W and M,
        // all-zero header (hlen too small), W set with a wrong binding
        pkt_buf = '{8'h80};
        queue_packet(1'b0);
        pkt_buf = '{8'h00};
        queue_packet(1'b0);
        pkt_buf = '{8'h00, 8'hFF, 8'hFF, 8'hCF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        queue_packet(1'b0);
        pkt_buf = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
        queue_packet(1'b0);
        pkt_buf = '{8'h00, 8'h20, 8'h00, 8'h20, 8'h12, 8'h34, 8'h56, 8'h78};
        queue_packet(1'b0);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (phase = 0; phase < 3; phase++)
        begin
            tx_idle_pct = (phase == 0) ? 14 : (phase == 1) ? 48 : 0;
            rx_idle_pct = (phase == 0) ? 48 : (phase == 1) ? 14 : 0;
            used = 0;
            while (used < PHASE_BYTES)
            begin
                // first packet of the second phase waits for a fully drained block
                add_packet((phase == 1 && used == 0) || $urandom_range(29) == 0, n);
                used += n;
            end
            while (byte_q.size() != 0 || pkt_if.valid)
                @(posedge clk);
        end

        while (expected_parses.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
